// ----- rtl/core/cshs_pkg.sv -----
`timescale 1ns / 1ps

package cshs_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_FLAGS = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_BUF  = 2'd1;
  localparam logic [1:0] ST_NO_FLAG = 2'd2;

  // Controller instructions, register addresses and bit masks.
  localparam logic [7:0] INSTR_READ_RX = 8'b1001_0000;
  localparam logic [7:0] INSTR_LOAD_TX = 8'b0100_0000;
  localparam logic [7:0] INSTR_BIT_MOD = 8'b0000_0101;
  localparam logic [7:0] REG_INTF      = 8'b0010_1100;
  localparam logic [7:0] TXREQ_MASK    = 8'b0000_1000;
  localparam logic [7:0] SIDL_HI_MASK  = 8'b1110_0000;
  localparam logic [7:0] SIDL_LO_MASK  = 8'b0000_0011;
  localparam logic [7:0] TX_CTRL_BASE  = 8'h30;
  localparam logic [7:0] EXT_FLAG      = 8'b0000_1000;

  localparam int unsigned NUM_TX_BUF   = 3;
  localparam int unsigned LOAD_BYTES   = 14;
  localparam logic [3:0]  MAX_DLC      = 4'd8;

  // Byte positions within the sequences.
  localparam logic [4:0] SEND_LOAD_END  = 5'd13;
  localparam logic [4:0] SEND_BM_INSTR  = 5'd14;
  localparam logic [4:0] SEND_BM_ADDR   = 5'd15;
  localparam logic [4:0] SEND_BM_MASK   = 5'd16;
  localparam logic [4:0] SEND_BM_DATA   = 5'd17;
  localparam logic [4:0] RXREAD_END     = 5'd14;
  localparam logic [4:0] CLR_BM_INSTR   = 5'd0;
  localparam logic [4:0] CLR_BM_ADDR    = 5'd1;
  localparam logic [4:0] CLR_BM_MASK    = 5'd2;
  localparam logic [4:0] CLR_BM_DATA    = 5'd3;

  // What a held item will emit.
  typedef enum logic [2:0] {
    K_SEND,
    K_FULL,
    K_RXREAD,
    K_CLEAR,
    K_NOFLAG,
    K_RECV
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [1:0]            buf_n;
    logic [2:0]            flag_bit;
    logic [13:0][7:0]      load_bytes;
    logic [28:0]           rx_id;
    logic                  rx_extended;
    logic [3:0]            rx_length;
    logic [63:0]           rx_payload;
  } item_t;

endpackage

// ----- rtl/core/cshs_if.sv -----
`timescale 1ns / 1ps

// Input channel: one item per transfer.
interface cshs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [28:0] frame_id;
  logic        is_extended;
  logic        is_remote;
  logic [3:0]  length_code;
  logic [63:0] payload;
  logic [7:0]  flag_byte;
  logic [39:0] raw_header;

  modport source (
    output valid, op, frame_id, is_extended, is_remote, length_code, payload,
           flag_byte, raw_header,
    input  ready
  );
  modport sink (
    input  valid, op, frame_id, is_extended, is_remote, length_code, payload,
           flag_byte, raw_header,
    output ready
  );
endinterface

// Result channel: one SPI byte or decoded frame per transfer.
interface cshs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  spi_byte;
  logic        end_of_transaction;
  logic        last;
  logic [1:0]  status;
  logic        rx_valid;
  logic [28:0] rx_id;
  logic        rx_extended;
  logic [3:0]  rx_length;
  logic [63:0] rx_payload;

  modport source (
    output valid, spi_byte, end_of_transaction, last, status, rx_valid, rx_id,
           rx_extended, rx_length, rx_payload,
    input  ready
  );
  modport sink (
    input  valid, spi_byte, end_of_transaction, last, status, rx_valid, rx_id,
           rx_extended, rx_length, rx_payload,
    output ready
  );
endinterface

// ----- rtl/core/cshs_decode.sv -----
`timescale 1ns / 1ps

module cshs_decode (
  input  logic [1:0]    op,
  input  logic [28:0]   frame_id,
  input  logic          is_extended,
  input  logic          is_remote,
  input  logic [3:0]    length_code,
  input  logic [63:0]   payload,
  input  logic [7:0]    flag_byte,
  input  logic [39:0]   raw_header,
  input  logic [2:0]    busy,
  output cshs_pkg::item_t item,
  output logic          has_result,
  output logic [2:0]    busy_nxt
);
  import cshs_pkg::*;

  logic [3:0] tx_len;
  logic [1:0] free_n;
  logic       all_busy;
  logic [7:0] sidh;
  logic [7:0] sidl;
  logic [7:0] eid8;
  logic [7:0] eid0;
  logic [2:0] low_bit;
  logic       any_flag;
  logic [7:0] r_sidh;
  logic [7:0] r_sidl;
  logic [7:0] r_eid8;
  logic [7:0] r_eid0;
  logic [3:0] r_len;
  logic [63:0] r_data;

  // Lowest free transmit buffer.
  always_comb begin
    all_busy = 1'b0;
    free_n   = 2'd0;
    if (!busy[0]) begin
      free_n = 2'd0;
    end else if (!busy[1]) begin
      free_n = 2'd1;
    end else if (!busy[2]) begin
      free_n = 2'd2;
    end else begin
      all_busy = 1'b1;
    end
  end

  // Identifier packing for the transmit buffer registers.
  always_comb begin
    tx_len = (length_code > MAX_DLC) ? MAX_DLC : length_code;
    if (is_extended) begin
      sidh = frame_id[28:21];
      sidl = EXT_FLAG | ({frame_id[20:18], 5'b0} & SIDL_HI_MASK)
           | ({6'b0, frame_id[17:16]} & SIDL_LO_MASK);
      eid8 = frame_id[15:8];
      eid0 = frame_id[7:0];
    end else begin
      sidh = frame_id[10:3];
      sidl = {frame_id[2:0], 5'b0} & SIDL_HI_MASK;
      eid8 = 8'd0;
      eid0 = 8'd0;
    end
  end

  // Highest-priority interrupt flag is the lowest set bit.
  always_comb begin
    low_bit  = 3'd0;
    any_flag = |flag_byte;
    for (int i = 7; i >= 0; i--) begin
      if (flag_byte[i]) begin
        low_bit = 3'(i);
      end
    end
  end

  // Received buffer header fields.
  always_comb begin
    r_sidh = raw_header[7:0];
    r_sidl = raw_header[15:8];
    r_eid8 = raw_header[23:16];
    r_eid0 = raw_header[31:24];
    r_len  = (raw_header[35:32] > MAX_DLC) ? MAX_DLC : raw_header[35:32];
    for (int i = 0; i < 8; i++) begin
      r_data[8*i +: 8] = (4'(i) < r_len) ? payload[8*i +: 8] : 8'd0;
    end
  end

  // Item assembly and busy-bit update.
  always_comb begin
    item             = '0;
    item.kind        = K_NOFLAG;
    has_result       = 1'b1;
    busy_nxt         = busy;
    item.buf_n       = free_n;
    item.flag_bit    = low_bit;
    item.load_bytes[0] = INSTR_LOAD_TX | {5'b0, free_n, 1'b0};
    item.load_bytes[1] = sidh;
    item.load_bytes[2] = sidl;
    item.load_bytes[3] = eid8;
    item.load_bytes[4] = eid0;
    item.load_bytes[5] = {1'b0, is_remote, 2'b0, tx_len};
    for (int i = 0; i < 8; i++) begin
      item.load_bytes[6 + i] = (!is_remote && (4'(i) < tx_len)) ? payload[8*i +: 8] : 8'd0;
    end
    unique case (op)
      OP_SEND: begin
        if (all_busy) begin
          item.kind = K_FULL;
        end else begin
          item.kind = K_SEND;
          busy_nxt  = busy | (3'b001 << free_n);
        end
      end
      OP_FLAGS: begin
        if (!any_flag) begin
          item.kind = K_NOFLAG;
        end else if (low_bit < 3'd2) begin
          item.kind = K_RXREAD;
        end else begin
          item.kind = K_CLEAR;
          if (low_bit <= 3'd4) begin
            busy_nxt = busy & ~(3'b001 << (low_bit - 3'd2));
          end
        end
      end
      OP_RECV: begin
        item.kind        = K_RECV;
        item.rx_extended = r_sidl[3];
        item.rx_length   = r_len;
        item.rx_payload  = r_data;
        if (r_sidl[3]) begin
          item.rx_id = {r_sidh, r_sidl[7:5], r_sidl[1:0], r_eid8, r_eid0};
        end else begin
          item.rx_id = {18'd0, r_sidh, r_sidl[7:5]};
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/can_spi_controller_host_sequencer.sv -----
`timescale 1ns / 1ps
// An accepted item is held in the item register, each result in the output register.
// One result per cycle unless the receiver stalls; a send yields 18 results, a
// receive-buffer read 15, a flag clear 4, a full, no-flag or decoded-frame item 1.
// The next item is taken in the cycle the previous item's last result enters the output.
// Reset clears the transmit-buffer busy bits, the held item and the output register.
module can_spi_controller_host_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  cshs_in_if.sink           in_if,
  cshs_out_if.source        out_if
);
  import cshs_pkg::*;

  logic [2:0]  busy_r;
  logic [2:0]  busy_nxt;
  item_t       dec_item;
  logic        dec_has_result;

  item_t       item_r;
  logic        item_valid_r;
  logic [4:0]  idx_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_eot_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;
  logic        out_rx_valid_r;
  logic [28:0] out_rx_id_r;
  logic        out_rx_ext_r;
  logic [3:0]  out_rx_len_r;
  logic [63:0] out_rx_data_r;

  logic        adv;
  logic        in_xfer;
  logic [7:0]  g_byte;
  logic        g_eot;
  logic        g_last;
  logic [1:0]  g_status;

  cshs_decode u_decode (
    .op          (in_if.op),
    .frame_id    (in_if.frame_id),
    .is_extended (in_if.is_extended),
    .is_remote   (in_if.is_remote),
    .length_code (in_if.length_code),
    .payload     (in_if.payload),
    .flag_byte   (in_if.flag_byte),
    .raw_header  (in_if.raw_header),
    .busy        (busy_r),
    .item        (dec_item),
    .has_result  (dec_has_result),
    .busy_nxt    (busy_nxt)
  );

  // Handshake: the output register moves when empty or taken.
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = !item_valid_r || (adv && g_last);
  assign in_xfer     = in_if.valid && in_if.ready;

  // Byte generator for the held item at the current position.
  always_comb begin
    g_byte   = 8'd0;
    g_eot    = 1'b0;
    g_last   = 1'b0;
    g_status = ST_OK;
    case (item_r.kind)
      K_SEND: begin
        if (idx_r <= SEND_LOAD_END) begin
          g_byte = item_r.load_bytes[idx_r[3:0]];
          g_eot  = (idx_r == SEND_LOAD_END);
        end else if (idx_r == SEND_BM_INSTR) begin
          g_byte = INSTR_BIT_MOD;
        end else if (idx_r == SEND_BM_ADDR) begin
          g_byte = TX_CTRL_BASE + {2'b0, item_r.buf_n, 4'b0};
        end else if (idx_r == SEND_BM_MASK) begin
          g_byte = TXREQ_MASK;
        end else begin
          g_byte = TXREQ_MASK;
          g_eot  = 1'b1;
          g_last = 1'b1;
        end
      end
      K_RXREAD: begin
        if (idx_r == 5'd0) begin
          g_byte = INSTR_READ_RX | {5'b0, item_r.flag_bit[0], 2'b0};
        end
        g_eot  = (idx_r == RXREAD_END);
        g_last = (idx_r == RXREAD_END);
      end
      K_CLEAR: begin
        case (idx_r)
          CLR_BM_INSTR: g_byte = INSTR_BIT_MOD;
          CLR_BM_ADDR:  g_byte = REG_INTF;
          CLR_BM_MASK:  g_byte = 8'b1 << item_r.flag_bit;
          default: begin
            g_byte = 8'd0;
            g_eot  = 1'b1;
            g_last = 1'b1;
          end
        endcase
      end
      K_FULL: begin
        g_status = ST_NO_BUF;
        g_last   = 1'b1;
      end
      K_NOFLAG: begin
        g_status = ST_NO_FLAG;
        g_last   = 1'b1;
      end
      default: begin
        g_last = 1'b1;
      end
    endcase
  end

  // Busy bits and the held item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= '0;
      item_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (in_xfer) begin
        busy_r <= busy_nxt;
      end
      if (item_valid_r && adv && !g_last) begin
        idx_r <= idx_r + 5'd1;
      end else if (in_xfer) begin
        item_valid_r <= dec_has_result;
        idx_r        <= '0;
      end else if (item_valid_r && adv) begin
        item_valid_r <= 1'b0;
        idx_r        <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= dec_item;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r     <= g_byte;
      out_eot_r      <= g_eot;
      out_last_r     <= g_last;
      out_status_r   <= g_status;
      out_rx_valid_r <= (item_r.kind == K_RECV);
      out_rx_id_r    <= (item_r.kind == K_RECV) ? item_r.rx_id : 29'd0;
      out_rx_ext_r   <= (item_r.kind == K_RECV) ? item_r.rx_extended : 1'b0;
      out_rx_len_r   <= (item_r.kind == K_RECV) ? item_r.rx_length : 4'd0;
      out_rx_data_r  <= (item_r.kind == K_RECV) ? item_r.rx_payload : 64'd0;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.spi_byte           = out_byte_r;
  assign out_if.end_of_transaction = out_eot_r;
  assign out_if.last               = out_last_r;
  assign out_if.status             = out_status_r;
  assign out_if.rx_valid           = out_rx_valid_r;
  assign out_if.rx_id              = out_rx_id_r;
  assign out_if.rx_extended        = out_rx_ext_r;
  assign out_if.rx_length          = out_rx_len_r;
  assign out_if.rx_payload         = out_rx_data_r;

  // The byte counter never runs past the longest sequence.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r |-> idx_r <= SEND_BM_DATA)
    else $error("byte counter out of range");

  // A failure status is always a single, final result.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_last_r && !out_eot_r))
    else $error("failure status not on a final result");

  // A decoded frame carries no SPI byte and ends its item.
  a_rx_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rx_valid_r) |-> (out_last_r && out_byte_r == 8'd0))
    else $error("decoded frame not a single result");

  // Once a non-final result is taken, the next one of the same item follows at once.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_if.ready && !out_last_r) |=> out_valid_r)
    else $error("gap inside an item's sequence");

endmodule

// ----- tb/sv/cshs_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the sequencer, predicts the SPI bytes and decoded
// frames for every accepted item and compares them with what comes out.
module cshs_checker (
  input  logic        clk,
  input  logic        rst_n,
  cshs_in_if          in_mon,
  cshs_out_if         out_mon,
  output int unsigned outstanding,
  output int unsigned mismatches
);
  import cshs_pkg::*;

  typedef struct packed {
    logic [7:0]  spi_byte;
    logic        eot;
    logic        last;
    logic [1:0]  status;
    logic        rx_valid;
    logic [28:0] rx_id;
    logic        rx_extended;
    logic [3:0]  rx_length;
    logic [63:0] rx_payload;
  } spi_result_t;

  // Results still owed by the block, oldest first.
  spi_result_t expected_spi_q[$];
  // Our own copy of the transmit-buffer occupancy.
  logic [2:0]  tx_busy;

  function automatic spi_result_t spi_byte_result(logic [7:0] b, logic eot);
    spi_result_t r;
    r = '0;
    r.spi_byte = b;
    r.eot = eot;
    return r;
  endfunction

  // Keeps the lowest n bytes of a data word and clears the rest.
  function automatic logic [63:0] clip_bytes(logic [63:0] v, logic [3:0] n);
    if (n >= MAX_DLC) begin
      return v;
    end
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // A bit-modify always closes its item, so the data byte carries both flags.
  task automatic queue_bit_modify(logic [7:0] addr, logic [7:0] mask, logic [7:0] data);
    spi_result_t r;
    expected_spi_q.push_back(spi_byte_result(INSTR_BIT_MOD, 1'b0));
    expected_spi_q.push_back(spi_byte_result(addr, 1'b0));
    expected_spi_q.push_back(spi_byte_result(mask, 1'b0));
    r = spi_byte_result(data, 1'b1);
    r.last = 1'b1;
    expected_spi_q.push_back(r);
  endtask

  task automatic predict_send();
    logic [28:0] id;
    logic [3:0]  len;
    logic [1:0]  n;
    logic        found;
    logic [7:0]  sidh, sidl, eid8, eid0;
    logic [63:0] data;
    spi_result_t r;
    id = in_mon.frame_id;
    len = (in_mon.length_code > MAX_DLC) ? MAX_DLC : in_mon.length_code;
    found = 1'b0;
    n = '0;
    for (int i = NUM_TX_BUF - 1; i >= 0; i--) begin
      if (!tx_busy[i]) begin
        n = i[1:0];
        found = 1'b1;
      end
    end
    // Every buffer taken: a single status result and nothing else.
    if (!found) begin
      r = spi_byte_result(8'h00, 1'b0);
      r.status = ST_NO_BUF;
      r.last = 1'b1;
      expected_spi_q.push_back(r);
      return;
    end
    if (in_mon.is_extended) begin
      sidh = id[28:21];
      sidl = EXT_FLAG | {id[20:18], 5'b0} | {6'b0, id[17:16]};
      eid8 = id[15:8];
      eid0 = id[7:0];
    end else begin
      sidh = id[10:3];
      sidl = {id[2:0], 5'b0};
      eid8 = 8'h00;
      eid0 = 8'h00;
    end
    data = in_mon.is_remote ? 64'd0 : clip_bytes(in_mon.payload, len);
    // Load-buffer transaction: instruction, header and eight data bytes.
    expected_spi_q.push_back(spi_byte_result(INSTR_LOAD_TX | {5'b0, n, 1'b0}, 1'b0));
    expected_spi_q.push_back(spi_byte_result(sidh, 1'b0));
    expected_spi_q.push_back(spi_byte_result(sidl, 1'b0));
    expected_spi_q.push_back(spi_byte_result(eid8, 1'b0));
    expected_spi_q.push_back(spi_byte_result(eid0, 1'b0));
    expected_spi_q.push_back(spi_byte_result({1'b0, in_mon.is_remote, 2'b00, len}, 1'b0));
    for (int i = 0; i < 8; i++) begin
      expected_spi_q.push_back(spi_byte_result(data[8 * i +: 8], i == 7));
    end
    // Request to send on the chosen buffer.
    queue_bit_modify(TX_CTRL_BASE + {2'b00, n, 4'b0000}, TXREQ_MASK, TXREQ_MASK);
    tx_busy[n] = 1'b1;
  endtask

  task automatic predict_flags();
    logic [7:0]  f;
    logic [2:0]  b;
    logic        found;
    spi_result_t r;
    f = in_mon.flag_byte;
    found = 1'b0;
    b = '0;
    for (int i = 7; i >= 0; i--) begin
      if (f[i]) begin
        b = i[2:0];
        found = 1'b1;
      end
    end
    if (!found) begin
      r = spi_byte_result(8'h00, 1'b0);
      r.status = ST_NO_FLAG;
      r.last = 1'b1;
      expected_spi_q.push_back(r);
    end else if (b < 3'd2) begin
      // Receive flag: read-buffer instruction followed by fourteen dummy bytes.
      expected_spi_q.push_back(spi_byte_result(INSTR_READ_RX | {5'b0, b[0], 2'b00}, 1'b0));
      for (int i = 1; i < 15; i++) begin
        r = spi_byte_result(8'h00, i == 14);
        r.last = (i == 14);
        expected_spi_q.push_back(r);
      end
    end else begin
      // Transmit flags also release their buffer.
      if (b <= 3'd4) begin
        tx_busy[b - 3'd2] = 1'b0;
      end
      queue_bit_modify(REG_INTF, 8'd1 << b, 8'h00);
    end
  endtask

  task automatic predict_recv();
    logic [39:0] h;
    logic [7:0]  sidh, sidl, eid8, eid0;
    logic [3:0]  len;
    spi_result_t r;
    h = in_mon.raw_header;
    sidh = h[7:0];
    sidl = h[15:8];
    eid8 = h[23:16];
    eid0 = h[31:24];
    len = (h[35:32] > MAX_DLC) ? MAX_DLC : h[35:32];
    r = spi_byte_result(8'h00, 1'b0);
    r.last = 1'b1;
    r.rx_valid = 1'b1;
    r.rx_extended = (sidl & EXT_FLAG) != 8'h00;
    if (r.rx_extended) begin
      r.rx_id = {sidh, sidl[7:5], sidl[1:0], eid8, eid0};
    end else begin
      r.rx_id = {18'd0, sidh, sidl[7:5]};
    end
    r.rx_length = len;
    r.rx_payload = clip_bytes(in_mon.payload, len);
    expected_spi_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    spi_result_t want;
    if (!rst_n) begin
      tx_busy = '0;
      mismatches = 0;
      expected_spi_q.delete();
    end else begin
      // Result transfer: compare with the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_spi_q.size() == 0) begin
          $error("unexpected result transfer, spi_byte 0x%0h", out_mon.spi_byte);
          mismatches++;
        end else begin
          want = expected_spi_q.pop_front();
          check_field("spi_byte", 64'(want.spi_byte), 64'(out_mon.spi_byte));
          check_field("end_of_transaction", 64'(want.eot),
                      64'(out_mon.end_of_transaction));
          check_field("last", 64'(want.last), 64'(out_mon.last));
          check_field("status", 64'(want.status), 64'(out_mon.status));
          check_field("rx_valid", 64'(want.rx_valid), 64'(out_mon.rx_valid));
          check_field("rx_id", 64'(want.rx_id), 64'(out_mon.rx_id));
          check_field("rx_extended", 64'(want.rx_extended), 64'(out_mon.rx_extended));
          check_field("rx_length", 64'(want.rx_length), 64'(out_mon.rx_length));
          check_field("rx_payload", want.rx_payload, out_mon.rx_payload);
        end
      end
      // Input transfer: work out what the item will produce.
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_SEND:  predict_send();
          OP_FLAGS: predict_flags();
          OP_RECV:  predict_recv();
          default: ;
        endcase
      end
    end
    outstanding = expected_spi_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cshs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_ITEMS = 180;

  typedef struct {
    logic [1:0]  op;
    logic [28:0] frame_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  length_code;
    logic [63:0] payload;
    logic [7:0]  flag_byte;
    logic [39:0] raw_header;
  } host_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count = 0;
  int unsigned outstanding;
  int unsigned mismatches;

  cshs_in_if  in_ch();
  cshs_out_if out_ch();

  can_spi_controller_host_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  cshs_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #5ns clk = ~clk;

  // The receiver stalls at random, one decision per cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one item, with random idle cycles first, and waits for its transfer.
  task automatic offer(input host_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= it.op;
    in_ch.frame_id    <= it.frame_id;
    in_ch.is_extended <= it.is_extended;
    in_ch.is_remote   <= it.is_remote;
    in_ch.length_code <= it.length_code;
    in_ch.payload     <= it.payload;
    in_ch.flag_byte   <= it.flag_byte;
    in_ch.raw_header  <= it.raw_header;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Every field random; the caller then shapes the fields that matter.
  function automatic host_item_t noise_item();
    host_item_t it;
    it.op          = 2'($urandom_range(3));
    it.frame_id    = 29'($urandom);
    it.is_extended = 1'($urandom_range(1));
    it.is_remote   = 1'($urandom_range(1));
    it.length_code = 4'($urandom_range(15));
    it.payload     = {$urandom, $urandom};
    it.flag_byte   = 8'($urandom_range(255));
    it.raw_header  = {8'($urandom_range(255)), 32'($urandom)};
    return it;
  endfunction

  task automatic send_frame(logic [28:0] id, logic ext, logic rem, logic [3:0] len,
                            logic [63:0] data);
    host_item_t it;
    it = noise_item();
    it.op = OP_SEND;
    it.frame_id = id;
    it.is_extended = ext;
    it.is_remote = rem;
    it.length_code = len;
    it.payload = data;
    offer(it);
  endtask

  task automatic raise_flags(logic [7:0] f);
    host_item_t it;
    it = noise_item();
    it.op = OP_FLAGS;
    it.flag_byte = f;
    offer(it);
  endtask

  task automatic hand_buffer(logic [39:0] hdr, logic [63:0] data);
    host_item_t it;
    it = noise_item();
    it.op = OP_RECV;
    it.raw_header = hdr;
    it.payload = data;
    offer(it);
  endtask

  // Random item: mostly sends and single flags so that buffers fill and drain.
  function automatic host_item_t random_item();
    host_item_t it;
    int unsigned sel;
    int unsigned k;
    it = noise_item();
    sel = $urandom_range(99);
    k = $urandom_range(9);
    if (sel < 40) begin
      it.op = OP_SEND;
      it.is_remote = ($urandom_range(9) == 0);
      it.length_code = (k == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    end else if (sel < 75) begin
      it.op = OP_FLAGS;
      if (k == 0) begin
        it.flag_byte = 8'h00;
      end else if (k < 3) begin
        it.flag_byte = 8'($urandom_range(255));
      end else if (k < 7) begin
        it.flag_byte = 8'd1 << $urandom_range(4, 2);
      end else begin
        it.flag_byte = 8'd1 << $urandom_range(7);
      end
    end else if (sel < 95) begin
      it.op = OP_RECV;
    end else begin
      it.op = 2'd3;
    end
    return it;
  endfunction

  initial begin
    host_item_t  it;
    int unsigned counted;
    in_ch.valid       = 1'b0;
    in_ch.op          = '0;
    in_ch.frame_id    = '0;
    in_ch.is_extended = 1'b0;
    in_ch.is_remote   = 1'b0;
    in_ch.length_code = '0;
    in_ch.payload     = '0;
    in_ch.flag_byte   = '0;
    in_ch.raw_header  = '0;
    rst_n             = 1'b0;
    send_idle_pct     = 6;
    recv_idle_pct     = 51;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty flags, all three buffers, the full case and every flag.
    raise_flags(8'h00);
    send_frame(29'h7FF, 1'b0, 1'b0, 4'd8, {64{1'b1}});
    send_frame(29'h1FFF_FFFF, 1'b1, 1'b1, 4'd15, {64{1'b1}});
    send_frame(29'd0, 1'b1, 1'b0, 4'd0, {$urandom, $urandom});
    send_frame(29'h555, 1'b0, 1'b0, 4'd3, {$urandom, $urandom});
    raise_flags(8'h04);
    send_frame(29'($urandom), 1'b1, 1'b0, 4'd9, {$urandom, $urandom});
    raise_flags(8'h08);
    raise_flags(8'h10);
    raise_flags(8'h01);
    raise_flags(8'h02);
    raise_flags(8'h20);
    raise_flags(8'h40);
    raise_flags(8'h80);
    raise_flags(8'hFF);
    raise_flags(8'hFC);
    send_frame(29'd0, 1'b0, 1'b0, 4'd0, 64'd0);
    hand_buffer({40{1'b1}}, {64{1'b1}});
    hand_buffer(40'd0, 64'd0);
    hand_buffer({4'h0, 4'hF, 8'h00, 8'h00, 8'hF7, 8'hFF}, {$urandom, $urandom});
    hand_buffer({4'h0, 4'h3, 16'($urandom), 8'h0B, 8'($urandom)}, {$urandom, $urandom});
    send_frame(29'($urandom), 1'b1, 1'b0, 4'd5, {$urandom, $urandom});
    it = noise_item();
    it.op = 2'd3;
    offer(it);

    // Random part in three idling phases; ignored items do not count.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 6;
      end else if (counted == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      it = random_item();
      offer(it);
      if (it.op != 2'd3) begin
        counted++;
      end
    end
    in_ch.valid <= 1'b0;

    // Drain every expected result, then allow for the pipeline latency.
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
